// ===== rtl/ucc_pkg.sv =====
// Package of the serial command console: sizes, character codes, message texts,
// state and command types shared by the controller and the datapath.
// Depends on nothing.
package ucc_pkg;

   localparam int LINE_LEN = 10;
   localparam int LIDX_W = $clog2(LINE_LEN);
   localparam int CNT_W = $clog2(LINE_LEN + 1);
   localparam int IDX_W = 6;
   localparam int MAX_N = LINE_LEN + 1;

   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_SAMPLE = 2'd1;
   localparam logic [1:0] OP_BUTTON = 2'd2;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] NUM_TENS = 8'(48 + MAX_N / 10);
   localparam logic [7:0] NUM_ONES = 8'(48 + MAX_N % 10);
   localparam bit NUM_TWO = (MAX_N >= 10);

   localparam int LEN_MAX = 36;
   localparam int LEN_CHARS = 12;
   localparam int LEN_SEL = 14;
   localparam int LEN_INV = 22;
   localparam int LEN_VADC = 13;
   localparam int LEN_EQ = 3;
   localparam int LEN_VAL = 8;

   localparam logic [8*LEN_MAX-1:0] MSG_MAX = "Max string length must be less than ";
   localparam logic [8*LEN_CHARS-1:0] MSG_CHARS = " characters!";
   localparam logic [8*LEN_SEL-1:0] MSG_SEL = "Selected ADC: ";
   localparam logic [8*LEN_INV-1:0] MSG_INV = "Invalid number of ADC!";
   localparam logic [8*LEN_VADC-1:0] MSG_VADC = "Value of ADC ";
   localparam logic [8*LEN_EQ-1:0] MSG_EQ = " = ";
   localparam logic [8*LEN_VAL-1:0] MSG_VAL = "Value = ";

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PARSE,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      K_ECHO,
      K_CR,
      K_SEL_OK,
      K_SEL_BAD,
      K_SHOW,
      K_MAX,
      K_BUTTON
   } kind_type;

   typedef enum logic [3:0] {
      P_ECHO,
      P_CRLF,
      P_MAX,
      P_NUM,
      P_CHARS,
      P_SEL,
      P_SELBYTE,
      P_INV,
      P_VADC,
      P_CHDIG,
      P_EQ,
      P_DIGITS,
      P_VAL
   } piece_type;

   typedef struct packed {
      piece_type piece;
      logic      final_piece;
   } seq_type;

   typedef struct packed {
      logic             store_char;
      logic             backspace;
      logic             clear_line;
      logic             store_sample;
      logic             load_disp;
      logic             parse_start;
      logic             parse_step;
      logic [1:0]       pidx;
      logic             commit;
      logic             dig_sub;
      logic             dig_clr;
      logic             emit;
      logic             last;
      piece_type        piece;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic in_cr;
      logic in_bs;
      logic line_full;
      logic m_set;
      logic m_sel;
      logic m_show;
      logic sel_ok;
      logic selb_zero;
      logic dig_ge;
      logic out_free;
   } status_type;

   function automatic logic [IDX_W-1:0] piece_len(piece_type p);
      logic [IDX_W-1:0] n;
      unique case (p)
         P_CRLF:   n = IDX_W'(2);
         P_MAX:    n = IDX_W'(LEN_MAX);
         P_NUM:    n = NUM_TWO ? IDX_W'(2) : IDX_W'(1);
         P_CHARS:  n = IDX_W'(LEN_CHARS);
         P_SEL:    n = IDX_W'(LEN_SEL);
         P_INV:    n = IDX_W'(LEN_INV);
         P_VADC:   n = IDX_W'(LEN_VADC);
         P_EQ:     n = IDX_W'(LEN_EQ);
         P_DIGITS: n = IDX_W'(4);
         P_VAL:    n = IDX_W'(LEN_VAL);
         default:  n = IDX_W'(1);
      endcase
      return n;
   endfunction

   function automatic seq_type seq_piece(kind_type k, logic [2:0] s);
      seq_type r;
      r = '{piece: P_CRLF, final_piece: 1'b1};
      unique case (k)
         K_ECHO: r = '{piece: P_ECHO, final_piece: 1'b1};
         K_CR:   r = '{piece: P_CRLF, final_piece: 1'b1};
         K_SEL_OK: begin
            case (s)
               3'd0:    r = '{piece: P_CRLF, final_piece: 1'b0};
               3'd1:    r = '{piece: P_SEL, final_piece: 1'b0};
               3'd2:    r = '{piece: P_SELBYTE, final_piece: 1'b0};
               default: r = '{piece: P_CRLF, final_piece: 1'b1};
            endcase
         end
         K_SEL_BAD: begin
            case (s)
               3'd0:    r = '{piece: P_CRLF, final_piece: 1'b0};
               3'd1:    r = '{piece: P_INV, final_piece: 1'b0};
               default: r = '{piece: P_CRLF, final_piece: 1'b1};
            endcase
         end
         K_SHOW: begin
            case (s)
               3'd0:    r = '{piece: P_CRLF, final_piece: 1'b0};
               3'd1:    r = '{piece: P_VADC, final_piece: 1'b0};
               3'd2:    r = '{piece: P_CHDIG, final_piece: 1'b0};
               3'd3:    r = '{piece: P_EQ, final_piece: 1'b0};
               3'd4:    r = '{piece: P_DIGITS, final_piece: 1'b0};
               default: r = '{piece: P_CRLF, final_piece: 1'b1};
            endcase
         end
         K_MAX: begin
            case (s)
               3'd0:    r = '{piece: P_CRLF, final_piece: 1'b0};
               3'd1:    r = '{piece: P_MAX, final_piece: 1'b0};
               3'd2:    r = '{piece: P_NUM, final_piece: 1'b0};
               3'd3:    r = '{piece: P_CHARS, final_piece: 1'b0};
               default: r = '{piece: P_CRLF, final_piece: 1'b1};
            endcase
         end
         K_BUTTON: begin
            case (s)
               3'd0:    r = '{piece: P_VAL, final_piece: 1'b0};
               3'd1:    r = '{piece: P_DIGITS, final_piece: 1'b0};
               default: r = '{piece: P_CRLF, final_piece: 1'b1};
            endcase
         end
         default: r = '{piece: P_CRLF, final_piece: 1'b1};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ucc_if.sv =====
// Handshake channels of the serial command console: input items and reply characters.
// Depends on nothing.
interface ucc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [9:0] payload;
   modport source(output valid, output opcode, output payload, input ready);
   modport sink(input valid, input opcode, input payload, output ready);
endinterface

interface ucc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  tx_byte;
   logic        last;
   logic [13:0] shown_value;
   logic        mux_channel;
   modport source(output valid, output tx_byte, output last, output shown_value,
                  output mux_channel, input ready);
   modport sink(input valid, input tx_byte, input last, input shown_value,
                input mux_channel, output ready);
endinterface

// ===== rtl/ucc_ctrl.sv =====
// Controller of the serial command console: accepts items and sequences the
// reply pieces. Depends on ucc_pkg.
module ucc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   output logic                req_ready,
   input  ucc_pkg::status_type st,
   output ucc_pkg::cmd_type    cmd
);
   import ucc_pkg::*;

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   logic [2:0]       step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   seq_type          cur;
   logic             piece_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= K_ECHO;
         step_ff  <= '0;
         idx_ff   <= '0;
         pcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
         pcnt_ff  <= pcnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      pcnt_in   = pcnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cur       = seq_piece(kind_ff, step_ff);
      piece_end = (idx_ff == piece_len(cur.piece) - IDX_W'(1));
      cmd.piece = cur.piece;
      cmd.idx   = idx_ff;
      cmd.pidx  = pcnt_ff;
      cmd.last  = cur.final_piece && piece_end;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            step_in   = '0;
            idx_in    = '0;
            pcnt_in   = '0;
            if (req_valid) begin
               case (req_opcode)
                  OP_BYTE: begin
                     if (st.in_cr) begin
                        cmd.parse_start = 1'b1;
                        state_in = st.m_set ? ST_PARSE : ST_COMMIT;
                     end else if (st.in_bs) begin
                        cmd.backspace = 1'b1;
                        kind_in  = K_ECHO;
                        state_in = ST_EMIT;
                     end else if (st.line_full) begin
                        cmd.clear_line = 1'b1;
                        kind_in  = K_MAX;
                        state_in = ST_EMIT;
                     end else begin
                        cmd.store_char = 1'b1;
                        kind_in  = K_ECHO;
                        state_in = ST_EMIT;
                     end
                  end
                  OP_SAMPLE: cmd.store_sample = 1'b1;
                  OP_BUTTON: begin
                     cmd.load_disp = 1'b1;
                     kind_in  = K_BUTTON;
                     state_in = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_PARSE: begin
            cmd.parse_step = 1'b1;
            pcnt_in = pcnt_ff + 2'd1;
            if (pcnt_ff == 2'd3) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (st.m_sel) begin
               kind_in = st.sel_ok ? K_SEL_OK : K_SEL_BAD;
            end else if (st.m_show) begin
               kind_in = K_SHOW;
            end else begin
               kind_in = K_CR;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cur.piece == P_SELBYTE && st.selb_zero) begin
               step_in = step_ff + 3'd1;
               idx_in  = '0;
            end else if (cur.piece == P_DIGITS && st.dig_ge) begin
               cmd.dig_sub = 1'b1;
            end else if (st.out_free) begin
               cmd.emit    = 1'b1;
               cmd.dig_clr = (cur.piece == P_DIGITS);
               if (piece_end) begin
                  idx_in  = '0;
                  step_in = step_ff + 3'd1;
                  if (cur.final_piece) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/ucc_datapath.sv =====
// Datapath of the serial command console: line store, command parsing, digit
// conversion, character selection and the reply register. Depends on ucc_pkg.
module ucc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [9:0]          req_payload,
   input  ucc_pkg::cmd_type    cmd,
   output ucc_pkg::status_type st,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_last,
   output logic [13:0]         rsp_shown_value,
   output logic                rsp_mux_channel
);
   import ucc_pkg::*;

   logic [7:0]       line_ff [LINE_LEN];
   logic [7:0]       line_in [LINE_LEN];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [13:0]      disp_ff, disp_in;
   logic [3:0]       rchan_ff, rchan_in;
   logic             mux_ff, mux_in;
   logic [9:0]       sample_ff, sample_in;
   logic [7:0]       byte_ff, byte_in;
   logic [7:0]       selb_ff, selb_in;
   logic             dmode_ff, dmode_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [13:0]      pval_ff, pval_in;
   logic [13:0]      rem_ff, rem_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             ov_ff, ov_in;
   logic [7:0]       otx_ff, otx_in;
   logic             olast_ff, olast_in;
   logic [13:0]      oshow_ff, oshow_in;
   logic             omux_ff, omux_in;

   logic [7:0]       in_byte, pc, sel_a, ch;
   logic             pc_dig, pc_blank, a_dig;
   logic [3:0]       sel;
   logic [13:0]      weight;
   logic [LIDX_W-1:0] pos, last_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            line_ff[i] <= '0;
         end
         count_ff  <= '0;
         disp_ff   <= '0;
         rchan_ff  <= '0;
         mux_ff    <= 1'b1;
         sample_ff <= '0;
         ov_ff     <= 1'b0;
      end else begin
         line_ff   <= line_in;
         count_ff  <= count_in;
         disp_ff   <= disp_in;
         rchan_ff  <= rchan_in;
         mux_ff    <= mux_in;
         sample_ff <= sample_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      selb_ff  <= selb_in;
      dmode_ff <= dmode_in;
      done_ff  <= done_in;
      neg_ff   <= neg_in;
      pval_ff  <= pval_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      otx_ff   <= otx_in;
      olast_ff <= olast_in;
      oshow_ff <= oshow_in;
      omux_ff  <= omux_in;
   end

   always_comb begin
      in_byte  = req_payload[7:0];
      pos      = count_ff[LIDX_W-1:0];
      last_pos = LIDX_W'(count_ff - CNT_W'(1));
      pc       = line_ff[LIDX_W'(4) + LIDX_W'(cmd.pidx)];
      pc_dig   = (pc >= 8'h30) && (pc <= 8'h39);
      pc_blank = (pc == 8'h20) || ((pc >= 8'h09) && (pc <= 8'h0D));
      sel_a    = line_ff[7];
      a_dig    = (sel_a >= 8'h30) && (sel_a <= 8'h39);
      sel      = a_dig ? sel_a[3:0] : 4'd0;
      case (cmd.idx[1:0])
         2'd0:    weight = 14'd1000;
         2'd1:    weight = 14'd100;
         2'd2:    weight = 14'd10;
         default: weight = 14'd1;
      endcase

      st.in_cr     = (in_byte == CH_CR);
      st.in_bs     = (in_byte == CH_BS);
      st.line_full = (count_ff >= CNT_W'(LINE_LEN));
      st.m_set     = (line_ff[0] == "s") && (line_ff[1] == "e") && (line_ff[2] == "t")
                     && (line_ff[3] == " ");
      st.m_sel     = (line_ff[0] == "s") && (line_ff[1] == "e") && (line_ff[2] == "l")
                     && (line_ff[3] == "e") && (line_ff[4] == "c") && (line_ff[5] == "t")
                     && (line_ff[6] == " ");
      st.m_show    = (line_ff[0] == "s") && (line_ff[1] == "h") && (line_ff[2] == "o")
                     && (line_ff[3] == "w") && (line_ff[4] == "A") && (line_ff[5] == "D")
                     && (line_ff[6] == "C");
      st.sel_ok    = (sel <= 4'd1);
      st.selb_zero = (selb_ff == 8'h00);
      st.dig_ge    = (rem_ff >= weight);
      st.out_free  = !ov_ff || rsp_ready;

      unique case (cmd.piece)
         P_ECHO:    ch = byte_ff;
         P_CRLF:    ch = cmd.idx[0] ? CH_LF : CH_CR;
         P_MAX:     ch = MSG_MAX[8*(LEN_MAX-1-int'(cmd.idx)) +: 8];
         P_NUM:     ch = (NUM_TWO && cmd.idx == '0) ? NUM_TENS : NUM_ONES;
         P_CHARS:   ch = MSG_CHARS[8*(LEN_CHARS-1-int'(cmd.idx)) +: 8];
         P_SEL:     ch = MSG_SEL[8*(LEN_SEL-1-int'(cmd.idx)) +: 8];
         P_SELBYTE: ch = selb_ff;
         P_INV:     ch = MSG_INV[8*(LEN_INV-1-int'(cmd.idx)) +: 8];
         P_VADC:    ch = MSG_VADC[8*(LEN_VADC-1-int'(cmd.idx)) +: 8];
         P_CHDIG:   ch = CH_ZERO + {4'h0, rchan_ff};
         P_EQ:      ch = MSG_EQ[8*(LEN_EQ-1-int'(cmd.idx)) +: 8];
         P_DIGITS:  ch = CH_ZERO | {4'h0, cnt_ff};
         P_VAL:     ch = MSG_VAL[8*(LEN_VAL-1-int'(cmd.idx)) +: 8];
         default:   ch = 8'h00;
      endcase

      line_in   = line_ff;
      count_in  = count_ff;
      disp_in   = disp_ff;
      rchan_in  = rchan_ff;
      mux_in    = mux_ff;
      sample_in = sample_ff;
      byte_in   = cmd.store_char || cmd.backspace ? in_byte : byte_ff;
      selb_in   = selb_ff;
      dmode_in  = dmode_ff;
      done_in   = done_ff;
      neg_in    = neg_ff;
      pval_in   = pval_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      ov_in     = ov_ff && !rsp_ready;
      otx_in    = otx_ff;
      olast_in  = olast_ff;
      oshow_in  = oshow_ff;
      omux_in   = omux_ff;

      if (cmd.store_char) begin
         line_in[pos] = in_byte;
         count_in     = count_ff + CNT_W'(1);
      end
      if (cmd.backspace && count_ff != '0) begin
         line_in[last_pos] = 8'h00;
         count_in          = count_ff - CNT_W'(1);
      end
      if (cmd.store_sample) begin
         sample_in = req_payload;
      end
      if (cmd.load_disp) begin
         rem_in = disp_ff;
         cnt_in = '0;
      end
      if (cmd.parse_start) begin
         dmode_in = 1'b0;
         done_in  = 1'b0;
         neg_in   = 1'b0;
         pval_in  = '0;
      end
      if (cmd.parse_step && !done_ff) begin
         if (!dmode_ff) begin
            if (pc_blank) begin
               dmode_in = 1'b0;
            end else if (pc == "+" || pc == "-") begin
               neg_in   = (pc == "-");
               dmode_in = 1'b1;
            end else if (pc_dig) begin
               pval_in  = {10'd0, pc[3:0]};
               dmode_in = 1'b1;
            end else begin
               done_in = 1'b1;
            end
         end else if (pc_dig) begin
            pval_in = (pval_ff << 3) + (pval_ff << 1) + {10'd0, pc[3:0]};
         end else begin
            done_in = 1'b1;
         end
      end
      if (cmd.commit) begin
         if (st.m_set) begin
            disp_in = neg_ff ? 14'd0 : pval_ff;
         end
         if (st.m_sel) begin
            rchan_in = sel;
            if (st.sel_ok) begin
               mux_in = sel[0];
            end
         end
         selb_in = sel_a;
         rem_in  = {4'd0, sample_ff};
         cnt_in  = '0;
      end
      if (cmd.clear_line || cmd.commit) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            line_in[i] = 8'h00;
         end
         count_in = '0;
      end
      if (cmd.dig_sub) begin
         rem_in = rem_ff - weight;
         cnt_in = cnt_ff + 4'd1;
      end
      if (cmd.dig_clr) begin
         cnt_in = '0;
      end
      if (cmd.emit) begin
         ov_in    = 1'b1;
         otx_in   = ch;
         olast_in = cmd.last;
         oshow_in = disp_ff;
         omux_in  = mux_ff;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_tx_byte     = otx_ff;
   assign rsp_last        = olast_ff;
   assign rsp_shown_value = oshow_ff;
   assign rsp_mux_channel = omux_ff;

endmodule

// ===== rtl/uart_command_console.sv =====
// Top level of the serial command console. An echoed character is registered in the emit
// state once the reply register is free; a line end adds a commit state, preceded by parse
// steps for a set command. Replies stream at one character per cycle while the receiver is
// ready and no digit subtraction is under way. The next item is taken the cycle after the
// last reply character is registered; samples never leave the idle state and go back to back.
// Synchronous reset empties the line, zeroes the display value and sample, picks channel 1.
module uart_command_console (
   input logic clock,
   input logic reset,
   ucc_req_if.sink   req_chan,
   ucc_rsp_if.source rsp_chan
);
   import ucc_pkg::*;

   cmd_type    cmd;
   status_type st;

   ucc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .st         (st),
      .cmd        (cmd)
   );

   ucc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_payload     (req_chan.payload),
      .cmd             (cmd),
      .st              (st),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_tx_byte     (rsp_chan.tx_byte),
      .rsp_last        (rsp_chan.last),
      .rsp_shown_value (rsp_chan.shown_value),
      .rsp_mux_channel (rsp_chan.mux_channel)
   );

endmodule

// ===== test/uart_command_console_test.sv =====
// Self-checking testbench of the serial command console: directed and random
// byte, sample and button traffic, with replies predicted and compared per field.
// Depends on ucc_pkg, ucc_if and the uart_command_console top level.
module uart_command_console_test;
   import ucc_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [7:0]  tx_byte;
      logic        last;
      logic [13:0] shown_value;
      logic        mux_channel;
   } reply_type;

   logic clock;
   logic reset;
   ucc_req_if req_chan();
   ucc_rsp_if rsp_chan();

   uart_command_console dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   logic [7:0]  line_bytes[LINE_LEN];
   int          line_fill;
   logic [13:0] display_value;
   logic [3:0]  report_chan;
   logic        mux_sel;
   logic [9:0]  sample_value;
   logic [7:0]  reply_chars[$];
   reply_type   pending_replies[$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          sent_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) reply_chars.push_back(s[i]);
   endfunction

   function automatic void add_crlf();
      reply_chars.push_back(CH_CR);
      reply_chars.push_back(CH_LF);
   endfunction

   function automatic void add_four(int v);
      v = v % 10000;
      reply_chars.push_back(8'(48 + v / 1000));
      reply_chars.push_back(8'(48 + (v / 100) % 10));
      reply_chars.push_back(8'(48 + (v / 10) % 10));
      reply_chars.push_back(8'(48 + v % 10));
   endfunction

   function automatic void empty_line();
      for (int i = 0; i < LINE_LEN; i++) line_bytes[i] = 8'h00;
      line_fill = 0;
   endfunction

   function automatic bit line_has(string pat);
      for (int i = 0; i < pat.len() && i < LINE_LEN; i++)
         if (line_bytes[i] != pat[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [13:0] set_number();
      int i = 4;
      bit neg = 1'b0;
      int v = 0;
      while (i < 8 && is_blank(line_bytes[i])) i++;
      if (i < 8 && (line_bytes[i] == "+" || line_bytes[i] == "-")) begin
         neg = (line_bytes[i] == "-");
         i++;
      end
      while (i < 8 && line_bytes[i] >= "0" && line_bytes[i] <= "9") begin
         v = v * 10 + (line_bytes[i] - 8'd48);
         i++;
      end
      return neg ? 14'd0 : 14'(v);
   endfunction

   function automatic void run_command();
      logic [7:0] arg;
      logic [3:0] sel;
      if (line_has("set ")) display_value = set_number();
      if (line_has("select ")) begin
         arg = line_bytes[7];
         sel = (arg >= "0" && arg <= "9") ? 4'(arg - 8'd48) : 4'd0;
         report_chan = sel;
         if (sel <= 1) begin
            mux_sel = sel[0];
            add_text("Selected ADC: ");
            if (arg != 8'h00) reply_chars.push_back(arg);
            add_crlf();
         end else begin
            add_text("Invalid number of ADC!");
            add_crlf();
         end
      end
      if (line_has("showADC")) begin
         add_text("Value of ADC ");
         reply_chars.push_back(8'(48 + report_chan));
         add_text(" = ");
         add_four(sample_value);
         add_crlf();
      end
   endfunction

   function automatic void predict_replies(logic [1:0] op, logic [9:0] pay);
      logic [7:0] b;
      reply_type r;
      reply_chars.delete();
      b = pay[7:0];
      if (op == OP_BYTE) begin
         if (b == CH_CR) begin
            add_crlf();
            run_command();
            empty_line();
         end else if (b == CH_BS) begin
            if (line_fill > 0) begin
               line_fill--;
               line_bytes[line_fill] = 8'h00;
            end
            reply_chars.push_back(CH_BS);
         end else if (line_fill >= LINE_LEN) begin
            add_crlf();
            add_text("Max string length must be less than ");
            if (MAX_N >= 10) reply_chars.push_back(8'(48 + MAX_N / 10));
            reply_chars.push_back(8'(48 + MAX_N % 10));
            add_text(" characters!");
            add_crlf();
            empty_line();
         end else begin
            reply_chars.push_back(b);
            line_bytes[line_fill] = b;
            line_fill++;
         end
      end else if (op == OP_SAMPLE) begin
         sample_value = pay;
      end else if (op == OP_BUTTON) begin
         add_text("Value = ");
         add_four(display_value);
         add_crlf();
      end
      foreach (reply_chars[k]) begin
         r.tx_byte = reply_chars[k];
         r.last = (k == reply_chars.size() - 1);
         r.shown_value = display_value;
         r.mux_channel = mux_sel;
         pending_replies.push_back(r);
      end
   endfunction

   task automatic send_item(logic [1:0] op, logic [9:0] pay);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.payload <= pay;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      predict_replies(op, pay);
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(OP_BYTE, {2'($urandom_range(3)), b});
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_BS);
      return c;
   endfunction

   always @(posedge clock) begin
      reply_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected transfer: tx_byte %h", rsp_chan.tx_byte);
            fail_count++;
         end else begin
            e = pending_replies.pop_front();
            if (rsp_chan.tx_byte !== e.tx_byte) begin
               $error("tx_byte expected %h actual %h", e.tx_byte, rsp_chan.tx_byte);
               fail_count++;
            end
            if (rsp_chan.last !== e.last) begin
               $error("last expected %b actual %b", e.last, rsp_chan.last);
               fail_count++;
            end
            if (rsp_chan.shown_value !== e.shown_value) begin
               $error("shown_value expected %0d actual %0d", e.shown_value,
                      rsp_chan.shown_value);
               fail_count++;
            end
            if (rsp_chan.mux_channel !== e.mux_channel) begin
               $error("mux_channel expected %b actual %b", e.mux_channel,
                      rsp_chan.mux_channel);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("uart_command_console: mismatch");
         $finish;
      end
   end

   task automatic test_line_editing();
      send_item(OP_BYTE, 10'h3FF);
      send_byte(CH_BS);
      send_text("ab");
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_text("0123456789Z");
      send_byte(8'h00);
      send_byte(CH_CR);
      send_item(OP_UNUSED, 10'h3FF);
   endtask

   task automatic test_commands();
      send_item(OP_SAMPLE, 10'h3FF);
      send_text("set  -99\r");
      send_text("set 9999\r");
      send_item(OP_BUTTON, 10'h000);
      send_text("set +12x\r");
      send_text("select 0\r");
      send_text("showADC\r");
      send_text("select 7\r");
      send_text("showADC\r");
      send_text("select \r");
      send_text("select q\r");
      send_text("select 1\r");
      send_item(OP_SAMPLE, 10'h000);
      send_text("showADC\r");
      send_item(OP_BUTTON, 10'h3FF);
   endtask

   task automatic type_random_line();
      string s;
      int kind;
      kind = $urandom_range(9);
      case (kind)
         0, 1: begin
            s = "set ";
            if ($urandom_range(3) == 0) s = {s, " "};
            case ($urandom_range(3))
               0: s = {s, "-"};
               1: s = {s, "+"};
               default: ;
            endcase
            repeat ($urandom_range(4)) s = {s, string'(8'(48 + $urandom_range(9)))};
            send_text(s);
            send_byte(CH_CR);
         end
         2, 3: begin
            send_text("select ");
            case ($urandom_range(3))
               0: send_byte(8'(48 + $urandom_range(1)));
               1: send_byte(8'(48 + $urandom_range(9)));
               2: send_byte(plain_char());
               default: ;
            endcase
            send_byte(CH_CR);
         end
         4: begin
            send_text("showADC");
            send_byte(CH_CR);
         end
         5: begin
            repeat ($urandom_range(9)) send_byte(8'($urandom_range(255)));
            send_byte(CH_CR);
         end
         6: repeat (LINE_LEN + 1) send_byte(plain_char());
         7: begin
            send_text("sex");
            send_byte(CH_BS);
            send_byte(CH_BS);
            send_text("et ");
            send_byte(8'(48 + $urandom_range(9)));
            send_byte(CH_CR);
         end
         8: send_item(OP_BUTTON, 10'($urandom_range(1023)));
         default: begin
            if ($urandom_range(4) == 0) send_item(OP_UNUSED, 10'($urandom_range(1023)));
            else send_item(OP_SAMPLE, 10'($urandom_range(1023)));
         end
      endcase
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int items);
      int start;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      start = sent_count;
      while (sent_count - start < items) type_random_line();
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_BYTE;
      req_chan.payload = '0;
      empty_line();
      display_value = '0;
      report_chan = '0;
      mux_sel = 1'b1;
      sample_value = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_line_editing();
      test_commands();
      test_random_traffic(0, 0, 90);
      test_random_traffic(60, 0, 90);
      test_random_traffic(0, 60, 90);
      test_random_traffic(21, 21, 90);
      req_chan.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_replies.size() == 0) begin
         $display("uart_command_console: match");
      end else begin
         $display("uart_command_console: mismatch");
      end
      $finish;
   end

endmodule
